### design/rwct_pkg.sv
package rwct_pkg;

   localparam int IDX_W    = 12;
   localparam int COLOR_W  = 24;
   localparam int COLUMN_W = 10;
   localparam int ROW_W    = 9;
   localparam int HEIGHT_W = 16;
   localparam int FRAC_W   = 16;

   // d = 256*row + 128*height - 128*screen_rows, nonnegative part
   localparam int D_W          = 25;
   localparam int ROW_SHIFT    = 8;
   localparam int HEIGHT_SHIFT = 7;

   localparam logic [COLOR_W-1:0] HALF_MASK = 24'h7F7F7F;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SHADE = 1'b1;

   typedef struct packed {
      logic                op;
      logic                wr;
      logic                dark;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic [HEIGHT_W-1:0] wall_height;
      logic [IDX_W-1:0]    index;
      logic [COLOR_W-1:0]  color;
   } side_type;

endpackage

### design/rwct_ram.sv
module rwct_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### design/rwct_front.sv
module rwct_front #(
   parameter int SCREEN_ROWS = 512,
   parameter int TEX_COLS    = 64,
   parameter int TEX_ROWS    = 64
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  rwct_pkg::side_type                          in_side,
   input  logic [rwct_pkg::FRAC_W-1:0]                 in_frac,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output rwct_pkg::side_type                          out_side,
   output logic [((TEX_COLS > 1) ? $clog2(TEX_COLS) : 1)-1:0] out_tx,
   output logic [rwct_pkg::D_W+$clog2(TEX_ROWS+1)-1:0] out_num
);

   localparam int TCW = (TEX_COLS > 1) ? $clog2(TEX_COLS) : 1;
   localparam int NW  = rwct_pkg::D_W + $clog2(TEX_ROWS + 1);
   localparam int PW  = rwct_pkg::FRAC_W + $clog2(TEX_COLS + 1);
   localparam int RW  = 17;
   localparam int DW  = rwct_pkg::D_W;

   localparam logic [RW-1:0] HALF_ROWS = RW'(SCREEN_ROWS / 2);
   localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_ROWS - 1);
   localparam logic [DW-1:0] D_BIAS    = DW'(SCREEN_ROWS << rwct_pkg::HEIGHT_SHIFT);

   logic [RW-1:0]      row_x;
   logic [RW-1:0]      half_h;
   logic               in_range;
   logic [DW-1:0]      d_sum;
   logic [DW-1:0]      d_in;
   logic [PW-1:0]      tx_prod;
   logic [TCW-1:0]     tx_in;
   rwct_pkg::side_type side_in;
   logic [NW-1:0]      num_in;

   logic               v1_ff, v2_ff;
   rwct_pkg::side_type side1_ff, side2_ff;
   logic [DW-1:0]      d1_ff;
   logic [TCW-1:0]     tx1_ff, tx2_ff;
   logic [NW-1:0]      num2_ff;
   logic               adv1, adv2;

   always_comb begin
      row_x    = RW'(in_side.row);
      half_h   = RW'(in_side.wall_height >> 1);
      in_range = (in_side.wall_height != '0) && (row_x + half_h >= HALF_ROWS) &&
                 (row_x < half_h + HALF_ROWS) && (row_x < LAST_ROW);
      d_sum    = (DW'(in_side.row) << rwct_pkg::ROW_SHIFT) +
                 (DW'(in_side.wall_height) << rwct_pkg::HEIGHT_SHIFT);
      d_in     = (d_sum >= D_BIAS) ? d_sum - D_BIAS : '0;
      tx_prod  = PW'(in_frac) * PW'(TEX_COLS);
      tx_in    = tx_prod[rwct_pkg::FRAC_W +: TCW];
      side_in    = in_side;
      side_in.wr = (in_side.op == rwct_pkg::OP_SHADE) && in_range;
      num_in   = NW'(d1_ff) * NW'(TEX_ROWS);
   end

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         side1_ff <= side_in;
         d1_ff    <= d_in;
         tx1_ff   <= tx_in;
      end
      if (adv2) begin
         side2_ff <= side1_ff;
         tx2_ff   <= tx1_ff;
         num2_ff  <= num_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_side  = side2_ff;
   assign out_tx    = tx2_ff;
   assign out_num   = num2_ff;

endmodule

### design/rwct_div.sv
module rwct_div #(
   parameter int TEX_COLS = 64,
   parameter int TEX_ROWS = 64
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  rwct_pkg::side_type                                 in_side,
   input  logic [((TEX_COLS > 1) ? $clog2(TEX_COLS) : 1)-1:0] in_tx,
   input  logic [rwct_pkg::D_W+$clog2(TEX_ROWS+1)-1:0]        in_num,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output rwct_pkg::side_type                                 out_side,
   output logic [((TEX_COLS > 1) ? $clog2(TEX_COLS) : 1)-1:0] out_tx,
   output logic [((TEX_ROWS > 1) ? $clog2(TEX_ROWS) : 1)-1:0] out_ty
);

   localparam int TCW = (TEX_COLS > 1) ? $clog2(TEX_COLS) : 1;
   localparam int TYW = (TEX_ROWS > 1) ? $clog2(TEX_ROWS) : 1;
   localparam int NW  = rwct_pkg::D_W + $clog2(TEX_ROWS + 1);

   // one quotient bit per stage, divisor is wall_height * 256
   logic               v_ff    [TYW];
   rwct_pkg::side_type side_ff [TYW];
   logic [TCW-1:0]     tx_ff   [TYW];
   logic [NW-1:0]      rem_ff  [TYW];
   logic [TYW-1:0]     q_ff    [TYW];
   logic               adv     [TYW+1];

   assign adv[TYW] = out_ready;

   for (genvar i = 0; i < TYW; i++) begin : g_stage
      localparam int B = TYW - 1 - i;

      logic               v_src;
      rwct_pkg::side_type side_src;
      logic [TCW-1:0]     tx_src;
      logic [NW-1:0]      rem_src;
      logic [TYW-1:0]     q_src;
      logic [NW-1:0]      trial;
      logic               fit;
      logic [NW-1:0]      rem_in;
      logic [TYW-1:0]     q_in;

      if (i == 0) begin : g_first
         assign v_src    = in_valid;
         assign side_src = in_side;
         assign tx_src   = in_tx;
         assign rem_src  = in_num;
         assign q_src    = '0;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign side_src = side_ff[i-1];
         assign tx_src   = tx_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign q_src    = q_ff[i-1];
      end

      always_comb begin
         trial   = NW'(side_src.wall_height) << (rwct_pkg::ROW_SHIFT + B);
         fit     = rem_src >= trial;
         rem_in  = fit ? rem_src - trial : rem_src;
         q_in    = q_src;
         q_in[B] = fit;
      end

      assign adv[i] = !v_ff[i] || adv[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i]) begin
            side_ff[i] <= side_src;
            tx_ff[i]   <= tx_src;
            rem_ff[i]  <= rem_in;
            q_ff[i]    <= q_in;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[TYW-1];
   assign out_side  = side_ff[TYW-1];
   assign out_tx    = tx_ff[TYW-1];
   assign out_ty    = q_ff[TYW-1];

endmodule

### design/rwct_fetch.sv
module rwct_fetch #(
   parameter int TEX_COLS = 64,
   parameter int TEX_ROWS = 64
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  rwct_pkg::side_type                                 in_side,
   input  logic [((TEX_COLS > 1) ? $clog2(TEX_COLS) : 1)-1:0] in_tx,
   input  logic [((TEX_ROWS > 1) ? $clog2(TEX_ROWS) : 1)-1:0] in_ty,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output logic [rwct_pkg::COLUMN_W-1:0]                      out_column,
   output logic [rwct_pkg::ROW_W-1:0]                         out_row,
   output logic [rwct_pkg::COLOR_W-1:0]                       pixel_color,
   output logic                                               write_pixel
);

   localparam int TYW = (TEX_ROWS > 1) ? $clog2(TEX_ROWS) : 1;
   localparam int SW0 = TYW + $clog2(TEX_COLS + 1) + 1;
   localparam int SW  = (SW0 > rwct_pkg::IDX_W) ? SW0 : rwct_pkg::IDX_W;

   logic [SW-1:0]                 addr_sum;
   logic [rwct_pkg::IDX_W-1:0]    addr_in;

   logic                          va_ff, vb_ff;
   rwct_pkg::side_type            sidea_ff, sideb_ff;
   logic [rwct_pkg::IDX_W-1:0]    addra_ff;
   logic                          b_free, a_go;
   logic                          is_load, is_shade;
   logic [rwct_pkg::COLOR_W-1:0]  rd_data;
   logic [rwct_pkg::COLOR_W-1:0]  shaded;

   assign addr_sum = SW'(in_ty) * SW'(TEX_COLS) + SW'(in_tx);
   assign addr_in  = (in_side.op == rwct_pkg::OP_SHADE) ? addr_sum[rwct_pkg::IDX_W-1:0]
                                                        : in_side.index;

   assign is_load  = va_ff && (sidea_ff.op == rwct_pkg::OP_LOAD);
   assign is_shade = va_ff && (sidea_ff.op == rwct_pkg::OP_SHADE);
   assign b_free   = !vb_ff || out_ready;
   assign a_go     = is_load || (is_shade && b_free);
   assign in_ready = !va_ff || a_go;

   // loads write at the same stage shades read, so store order follows word order
   rwct_ram #(
      .WIDTH (rwct_pkg::COLOR_W),
      .DEPTH (1 << rwct_pkg::IDX_W)
   ) u_texture (
      .clock   (clock),
      .wr_en   (is_load),
      .wr_addr (addra_ff),
      .wr_data (sidea_ff.color),
      .rd_en   (is_shade && b_free),
      .rd_addr (addra_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            va_ff <= in_valid;
         end
         if (b_free) begin
            vb_ff <= is_shade;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         sidea_ff <= in_side;
         addra_ff <= addr_in;
      end
      if (b_free) begin
         sideb_ff <= sidea_ff;
      end
   end

   assign shaded      = sideb_ff.dark ? ((rd_data >> 1) & rwct_pkg::HALF_MASK) : rd_data;
   assign out_valid   = vb_ff;
   assign out_column  = sideb_ff.column;
   assign out_row     = sideb_ff.row;
   assign write_pixel = sideb_ff.wr;
   assign pixel_color = sideb_ff.wr ? shaded : '0;

endmodule

### design/raycast_wall_column_texturer_top.sv
// Pipeline from accepted word to result word: two front stages, one divider stage
// per texture-row bit (TYW = clog2(TEX_ROWS), and 1 when TEX_ROWS is 1), address and
// texture read. Throughput: one word per cycle, loads and shades alike,
// when rsp_tready does not stall; loads give no result.
// Reset: synchronous, active high, clears pipeline valids only; texture memory is
// not cleared and holds garbage until loaded.
module raycast_wall_column_texturer_top #(
   parameter int SCREEN_ROWS = 512,
   parameter int TEX_COLS    = 64,
   parameter int TEX_ROWS    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // texel_index, texel_color, column, row, wall_height, wall_frac, dark_side
   input  logic [87:0] req_tdata,
   // op
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_column, out_row, pixel_color, write_pixel, zero pad
   output logic [47:0] rsp_tdata
);

   localparam int TCW = (TEX_COLS > 1) ? $clog2(TEX_COLS) : 1;
   localparam int TYW = (TEX_ROWS > 1) ? $clog2(TEX_ROWS) : 1;
   localparam int NW  = rwct_pkg::D_W + $clog2(TEX_ROWS + 1);

   rwct_pkg::side_type            in_side;
   logic [rwct_pkg::FRAC_W-1:0]   in_frac;

   logic                          f_valid, f_ready;
   rwct_pkg::side_type            f_side;
   logic [TCW-1:0]                f_tx;
   logic [NW-1:0]                 f_num;

   logic                          d_valid, d_ready;
   rwct_pkg::side_type            d_side;
   logic [TCW-1:0]                d_tx;
   logic [TYW-1:0]                d_ty;

   logic [rwct_pkg::COLUMN_W-1:0] out_column;
   logic [rwct_pkg::ROW_W-1:0]    out_row;
   logic [rwct_pkg::COLOR_W-1:0]  pixel_color;
   logic                          write_pixel;

   always_comb begin
      in_side.op          = req_tuser;
      in_side.wr          = 1'b0;
      in_side.index       = req_tdata[11:0];
      in_side.color       = req_tdata[35:12];
      in_side.column      = req_tdata[45:36];
      in_side.row         = req_tdata[54:46];
      in_side.wall_height = req_tdata[70:55];
      in_side.dark        = req_tdata[87];
      in_frac             = req_tdata[86:71];
   end

   rwct_front #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .TEX_COLS    (TEX_COLS),
      .TEX_ROWS    (TEX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_side   (in_side),
      .in_frac   (in_frac),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_side  (f_side),
      .out_tx    (f_tx),
      .out_num   (f_num)
   );

   rwct_div #(
      .TEX_COLS (TEX_COLS),
      .TEX_ROWS (TEX_ROWS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_side   (f_side),
      .in_tx     (f_tx),
      .in_num    (f_num),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_side  (d_side),
      .out_tx    (d_tx),
      .out_ty    (d_ty)
   );

   rwct_fetch #(
      .TEX_COLS (TEX_COLS),
      .TEX_ROWS (TEX_ROWS)
   ) u_fetch (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_ready    (d_ready),
      .in_side     (d_side),
      .in_tx       (d_tx),
      .in_ty       (d_ty),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_column  (out_column),
      .out_row     (out_row),
      .pixel_color (pixel_color),
      .write_pixel (write_pixel)
   );

   assign rsp_tdata = {4'b0000, write_pixel, pixel_color, out_row, out_column};

endmodule

### dv/raycast_wall_column_texturer_top_test.sv
module raycast_wall_column_texturer_top_test;

   localparam int SCREEN_ROWS = 512;
   localparam int TEX_COLS    = 64;
   localparam int TEX_ROWS    = 64;
   localparam int STORE_DEPTH = 4096;
   localparam int PIPE_LAT    = $clog2(TEX_ROWS) + 4;
   localparam int TOTAL_WORDS = 1300;
   localparam int QUIET_FROM  = 1140;
   localparam int DRAIN_AT    = 600;

   typedef struct {
      logic                          op;
      logic [rwct_pkg::IDX_W-1:0]    index;
      logic [rwct_pkg::COLOR_W-1:0]  color;
      logic [rwct_pkg::COLUMN_W-1:0] column;
      logic [rwct_pkg::ROW_W-1:0]    row;
      logic [rwct_pkg::HEIGHT_W-1:0] height;
      logic [rwct_pkg::FRAC_W-1:0]   frac;
      logic                          dark;
   } texel_word_type;

   typedef struct {
      logic [rwct_pkg::COLUMN_W-1:0] column;
      logic [rwct_pkg::ROW_W-1:0]    row;
      logic [rwct_pkg::COLOR_W-1:0]  color;
      logic                          write;
   } pixel_type;

   typedef struct {
      texel_word_type               w;
      bit                           typed;
      logic [rwct_pkg::COLOR_W-1:0] exp_color;
      logic                         exp_write;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   logic [rwct_pkg::COLOR_W-1:0] texels [STORE_DEPTH];
   bit                           loaded [STORE_DEPTH];
   pixel_type                    pixel_q [$];
   int                           errors;
   int                           words;
   bit                           quiet;

   // extremes, empty spans, screen bottom, dark side, full-screen walls
   dir_row_type dir_table [21] = '{
      '{'{rwct_pkg::OP_LOAD,  12'd0,    24'hFFFFFF, 10'd0,    9'd0,   16'd0,     16'h0000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_LOAD,  12'd4095, 24'h000000, 10'd0,    9'd0,   16'd0,     16'h0000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_LOAD,  12'd2048, 24'hFFFFFF, 10'd0,    9'd0,   16'd0,     16'h0000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_LOAD,  12'd2111, 24'hABCDEF, 10'd0,    9'd0,   16'd0,     16'h0000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_LOAD,  12'd63,   24'h808080, 10'd0,    9'd0,   16'd0,     16'h0000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd1023, 9'd256, 16'd0,     16'hFFFF, 1'b1},
        1, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd5,    9'd256, 16'd1,     16'h8000, 1'b0},
        1, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd7,    9'd0,   16'd100,   16'h1234, 1'b0},
        1, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd1023, 9'd511, 16'd1022,  16'h0000, 1'b0},
        1, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd0,    9'd256, 16'd512,   16'h0000, 1'b0},
        1, 24'hFFFFFF, 1'b1},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd1023, 9'd256, 16'd512,   16'h0000, 1'b1},
        1, 24'h7F7F7F, 1'b1},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd10,   9'd255, 16'd2,     16'hFFFF, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd11,   9'd256, 16'd2,     16'hFFFF, 1'b1},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd12,   9'd0,   16'd65535, 16'h0000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd13,   9'd511, 16'd65535, 16'hFFFF, 1'b0},
        1, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd14,   9'd510, 16'd65535, 16'hFFFF, 1'b1},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd15,   9'd510, 16'd1022,  16'h4000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd16,   9'd0,   16'd1023,  16'hC000, 1'b0},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd17,   9'd300, 16'd600,   16'h1234, 1'b1},
        0, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd18,   9'd0,   16'd511,   16'h2222, 1'b0},
        1, 24'h0, 1'b0},
      '{'{rwct_pkg::OP_SHADE, 12'd0,    24'h0,      10'd19,   9'd1,   16'd511,   16'h2222, 1'b0},
        0, 24'h0, 1'b0}
   };

   raycast_wall_column_texturer_top #(
      .SCREEN_ROWS(SCREEN_ROWS),
      .TEX_COLS   (TEX_COLS),
      .TEX_ROWS   (TEX_ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   // row inside the clamped draw span, and the texel it samples
   function automatic bit fetch_slot(input texel_word_type w, output int addr);
      longint h, half, first, stop, y, tx, d, ty;
      h     = longint'(w.height);
      y     = longint'(w.row);
      half  = h / 2;
      first = SCREEN_ROWS / 2 - half;
      if (first < 0) first = 0;
      stop  = half + SCREEN_ROWS / 2;
      if (stop >= SCREEN_ROWS) stop = SCREEN_ROWS - 1;
      addr  = 0;
      if (h == 0 || y < first || y >= stop) return 1'b0;
      tx = ((longint'(w.frac) * TEX_COLS) >> 16) % TEX_COLS;
      d  = y * 256 - longint'(SCREEN_ROWS) * 128 + h * 128;
      ty = ((d * TEX_ROWS) / h) / 256;
      if (ty < 0) ty = 0;
      addr = int'((ty * TEX_COLS + tx) % STORE_DEPTH);
      return 1'b1;
   endfunction

   function automatic pixel_type shade_pixel(input texel_word_type w);
      pixel_type p;
      int        addr;
      p.column = w.column;
      p.row    = w.row;
      p.color  = '0;
      p.write  = fetch_slot(w, addr);
      if (p.write) begin
         p.color = texels[addr];
         if (w.dark) p.color = (p.color >> 1) & rwct_pkg::HALF_MASK;
      end
      return p;
   endfunction

   task automatic push_word(input texel_word_type w, input bit typed,
                            input pixel_type typed_pix);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tdata  <= {w.dark, w.frac, w.height, w.row, w.column, w.color, w.index};
      req_tuser  <= w.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words++;
      if (w.op == rwct_pkg::OP_LOAD) begin
         texels[w.index] = w.color;
         loaded[w.index] = 1'b1;
      end else begin
         pixel_q.push_back(typed ? typed_pix : shade_pixel(w));
      end
   endtask

   // a shade that would sample an empty texel gets that texel loaded first
   task automatic send_item(input texel_word_type w, input bit typed,
                            input pixel_type typed_pix);
      texel_word_type ld;
      int             addr;
      if (w.op == rwct_pkg::OP_SHADE && fetch_slot(w, addr) && !loaded[addr]) begin
         ld       = w;
         ld.op    = rwct_pkg::OP_LOAD;
         ld.index = addr[rwct_pkg::IDX_W-1:0];
         ld.color = rwct_pkg::COLOR_W'($urandom);
         push_word(ld, 1'b0, typed_pix);
      end
      push_word(w, typed, typed_pix);
   endtask

   function automatic logic [rwct_pkg::HEIGHT_W-1:0] pick_height();
      case ($urandom_range(0, 9))
         0:          return '0;
         1, 2, 3, 4: return rwct_pkg::HEIGHT_W'($urandom_range(1, 600));
         5, 6:       return rwct_pkg::HEIGHT_W'($urandom_range(600, 2000));
         7: begin
            case ($urandom_range(0, 6))
               0: return 16'd1;
               1: return 16'd2;
               2: return 16'd511;
               3: return 16'd512;
               4: return 16'd1022;
               5: return 16'd1023;
               default: return 16'd65535;
            endcase
         end
         default:    return rwct_pkg::HEIGHT_W'($urandom);
      endcase
   endfunction

   initial begin
      texel_word_type w;
      pixel_type      tp;
      int             lo, hi, r, len, half;
      bit             drained;
      errors     = 0;
      words      = 0;
      quiet      = 1'b0;
      drained    = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rwct_pkg::OP_LOAD;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         tp = '{dir_table[i].w.column, dir_table[i].w.row,
                dir_table[i].exp_color, dir_table[i].exp_write};
         send_item(dir_table[i].w, dir_table[i].typed, tp);
      end

      while (words < TOTAL_WORDS) begin
         if (words >= QUIET_FROM) quiet = 1'b1;
         if (!drained && words >= DRAIN_AT) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pixel_q.size() != 0);
         end
         w.index  = rwct_pkg::IDX_W'($urandom);
         w.color  = rwct_pkg::COLOR_W'($urandom);
         w.column = rwct_pkg::COLUMN_W'($urandom);
         w.height = pick_height();
         w.frac   = rwct_pkg::FRAC_W'($urandom);
         w.dark   = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 4) == 0) begin
            w.op  = rwct_pkg::OP_LOAD;
            w.row = rwct_pkg::ROW_W'($urandom);
            send_item(w, 1'b0, tp);
         end else if ($urandom_range(0, 5) == 0) begin
            w.op  = rwct_pkg::OP_SHADE;
            w.row = rwct_pkg::ROW_W'($urandom);
            send_item(w, 1'b0, tp);
         end else begin
            // one wall slice, walked row by row as the renderer does
            w.op = rwct_pkg::OP_SHADE;
            half = int'(w.height) / 2;
            lo   = SCREEN_ROWS / 2 - half;
            if (lo < 0) lo = 0;
            hi   = SCREEN_ROWS / 2 + half;
            if (hi > SCREEN_ROWS - 1) hi = SCREEN_ROWS - 1;
            r    = $urandom_range(lo > 3 ? lo - 3 : 0, hi);
            len  = $urandom_range(1, 32);
            repeat (len) begin
               if (r < SCREEN_ROWS) begin
                  w.row = rwct_pkg::ROW_W'(r);
                  send_item(w, 1'b0, tp);
               end
               r++;
            end
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pixel_q.size() != 0);
      repeat (4 * PIPE_LAT) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.column = rsp_tdata[9:0];
         got.row    = rsp_tdata[18:10];
         got.color  = rsp_tdata[42:19];
         got.write  = rsp_tdata[43];
         if (pixel_q.size() == 0) begin
            note_mismatch("pixel word with nothing pending");
         end else begin
            want = pixel_q.pop_front();
            if (got.column !== want.column)
               note_mismatch($sformatf("column %0d, want %0d", got.column, want.column));
            if (got.row !== want.row)
               note_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
            if (got.color !== want.color)
               note_mismatch($sformatf("color %06h, want %06h (col %0d row %0d)",
                                       got.color, want.color, want.column, want.row));
            if (got.write !== want.write)
               note_mismatch($sformatf("write %0b, want %0b (col %0d row %0d)",
                                       got.write, want.write, want.column, want.row));
         end
      end
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### raycast_wall_column_texturer_top.f
design/rwct_pkg.sv
design/rwct_ram.sv
design/rwct_front.sv
design/rwct_div.sv
design/rwct_fetch.sv
design/raycast_wall_column_texturer_top.sv
dv/raycast_wall_column_texturer_top_test.sv
